// ===== hw/rtl/ipv4_dotted_text_parser_top_assert.svh =====
// ============================================================================
// IPv4 parser assertion macros
// Shared concurrent assertion wrappers for the IPv4 dotted text parser.
// ============================================================================
`ifndef IPV4_DOTTED_TEXT_PARSER_TOP_ASSERT_SVH
`define IPV4_DOTTED_TEXT_PARSER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset
`define IPV4P_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ipv4 parser assertion failed")

// Next-cycle implication, checked outside reset
`define IPV4P_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ipv4 parser assertion failed")

`else

`define IPV4P_ASSERT_IMP(lbl, ante, cons)
`define IPV4P_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== hw/rtl/ipv4p_pkg.sv =====
// ============================================================================
// IPv4 parser package
// Character codes, the host name table and the types shared by the parser.
// ============================================================================
package ipv4p_pkg;

  localparam logic [7:0]  CHAR_END   = 8'h00;
  localparam logic [7:0]  CHAR_SPACE = 8'h20;
  localparam logic [7:0]  CHAR_DOT   = 8'h2e;
  localparam logic [7:0]  CHAR_DIG0  = 8'h30;
  localparam logic [7:0]  CHAR_DIG9  = 8'h39;

  localparam logic [3:0]  NAME_LEN      = 4'd9;
  localparam logic [31:0] LOOPBACK_ADDR = (32'd127 << 24) | 32'h1;

  localparam logic [8:0]  OCTET_MAX   = 9'd255;
  localparam logic [11:0] OCTET_SAT   = 12'd256;
  localparam logic [2:0]  FIELD_SAT   = 3'd5;
  localparam logic [2:0]  FIELD_FULL  = 3'd4;

  // Request from the input register into the parser core
  typedef struct packed {
    logic       fire;
    logic [7:0] ch;
  } chr_req_t;

  // Result of one string
  typedef struct packed {
    logic        valid_res;
    logic [31:0] address;
  } res_t;

  // Characters of the loopback host name
  function automatic logic [7:0] host_name_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = 8'h6c; // l
      4'd1:    c = 8'h6f; // o
      4'd2:    c = 8'h63; // c
      4'd3:    c = 8'h61; // a
      4'd4:    c = 8'h6c; // l
      4'd5:    c = 8'h68; // h
      4'd6:    c = 8'h6f; // o
      4'd7:    c = 8'h73; // s
      4'd8:    c = 8'h74; // t
      default: c = CHAR_END;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/ipv4_dotted_text_parser_top.sv =====
// A result is loaded into the result register when its end character leaves the input register.
// Throughput: one character per cycle unless an end character waits on the result side; the
// single-pass core updates all state in the cycle a character leaves the input register.
// An end character waits in the input register while a result is stalled.
// Reset (rst, synchronous) empties both registers and restarts the parse.
// ============================================================================
// IPv4 dotted text parser top level
// Parses zero-terminated dotted-decimal strings into 32-bit addresses.
// ============================================================================
`include "ipv4_dotted_text_parser_top_assert.svh"

module ipv4_dotted_text_parser_top import ipv4p_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        valid_res,
  output logic [31:0] address
);

  chr_req_t req;
  res_t     res;
  logic     res_fire;
  logic     out_ready;

  // Hold incoming characters
  ipv4p_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .char_code (char_code),
    .out_ready (out_ready),
    .req       (req)
  );

  // Advance the parse state
  ipv4p_core u_core (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .res_fire (res_fire),
    .res      (res)
  );

  // Hold results for the downstream side
  ipv4p_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (res_fire),
    .res       (res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .valid_res (valid_res),
    .address   (address)
  );

  `IPV4P_ASSERT_IMP(a_end_needs_room, res_fire, out_ready);
  `IPV4P_ASSERT_NXT(a_end_gives_result, res_fire, out_valid);
  `IPV4P_ASSERT_IMP(a_fail_zero_addr, out_valid && !valid_res, address == 32'd0);

endmodule

// ===== hw/rtl/ipv4p_in_reg.sv =====
// ============================================================================
// IPv4 parser input register
// Holds one character and hands it to the core when the result side allows.
// ============================================================================
module ipv4p_in_reg import ipv4p_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] char_code,
  input  logic       out_ready,
  output chr_req_t   req
);

  logic       full;
  logic [7:0] ch_q;
  logic       take;

  // Consume a held character; an end character needs room at the output
  assign take     = full && ((ch_q != CHAR_END) || out_ready);
  assign in_stall = full && !take;
  assign req.fire = take;
  assign req.ch   = ch_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else begin
      full <= in_valid || (full && !take);
    end
  end

  // Load a new request whenever the slot is free this cycle
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      ch_q <= char_code;
    end
  end

endmodule

// ===== hw/rtl/ipv4p_core.sv =====
// ============================================================================
// IPv4 parser core
// Per-character state update: octet build, field commit and name match.
// ============================================================================
module ipv4p_core import ipv4p_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  chr_req_t req,
  output logic     res_fire,
  output res_t     res
);

  typedef enum logic [1:0] {
    PH_LEAD   = 2'd0,
    PH_FIELDS = 2'd1,
    PH_TRAIL  = 2'd2
  } phase_t;

  phase_t      phase,      phase_next;
  logic [8:0]  octet,      octet_next;
  logic [2:0]  fcount,     fcount_next;
  logic [31:0] accum,      accum_next;
  logic [3:0]  name_pos,   name_pos_next;
  logic        name_match, name_match_next;
  logic        failed,     failed_next;

  logic [2:0]  cnt_c;
  logic        fail_c;
  logic [31:0] acc_c;
  logic [11:0] oct_mul;
  logic [11:0] oct_sum;
  logic        is_digit;
  logic        do_commit;
  logic        end_fail;
  logic [2:0]  end_cnt;
  logic [31:0] end_acc;
  logic        end_ok;

  // Field commit values
  always_comb begin
    cnt_c  = (fcount < FIELD_SAT) ? fcount + 3'd1 : fcount;
    fail_c = failed || (octet > OCTET_MAX) || (cnt_c > FIELD_FULL);
    acc_c  = {accum[23:0], octet[7:0]};
  end

  // Decimal accumulate, saturating
  always_comb begin
    is_digit = (req.ch >= CHAR_DIG0) && (req.ch <= CHAR_DIG9);
    oct_mul  = ({3'b000, octet} << 3) + ({3'b000, octet} << 1);
    oct_sum  = oct_mul + {4'd0, req.ch - CHAR_DIG0};
  end

  // End of string result
  always_comb begin
    do_commit = !failed && (phase != PH_TRAIL);
    end_fail  = do_commit ? fail_c : failed;
    end_cnt   = do_commit ? cnt_c  : fcount;
    end_acc   = do_commit ? acc_c  : accum;
    end_ok    = !end_fail && (end_cnt == FIELD_FULL);
    if (name_match && (name_pos == NAME_LEN)) begin
      res.valid_res = 1'b1;
      res.address   = LOOPBACK_ADDR;
    end else begin
      res.valid_res = end_ok;
      res.address   = end_ok ? end_acc : 32'd0;
    end
  end

  assign res_fire = req.fire && (req.ch == CHAR_END);

  // Next state for one character
  always_comb begin
    phase_next      = phase;
    octet_next      = octet;
    fcount_next     = fcount;
    accum_next      = accum;
    name_pos_next   = name_pos;
    name_match_next = name_match;
    failed_next     = failed;
    if (req.ch == CHAR_END) begin
      phase_next      = PH_LEAD;
      octet_next      = 9'd0;
      fcount_next     = 3'd0;
      accum_next      = 32'd0;
      name_pos_next   = 4'd0;
      name_match_next = 1'b1;
      failed_next     = 1'b0;
    end else begin
      if (name_match && (name_pos < NAME_LEN) && (req.ch == host_name_char(name_pos))) begin
        name_pos_next = name_pos + 4'd1;
      end else begin
        name_match_next = 1'b0;
      end
      if (!failed) begin
        if (phase == PH_TRAIL) begin
          if (req.ch != CHAR_SPACE) begin
            failed_next = 1'b1;
          end
        end else if (!((phase == PH_LEAD) && (req.ch == CHAR_SPACE))) begin
          phase_next = PH_FIELDS;
          if (is_digit) begin
            octet_next = (oct_sum > OCTET_SAT) ? OCTET_SAT[8:0] : oct_sum[8:0];
          end else if ((req.ch == CHAR_DOT) || (req.ch == CHAR_SPACE)) begin
            fcount_next = cnt_c;
            failed_next = fail_c;
            accum_next  = acc_c;
            octet_next  = 9'd0;
            if (req.ch == CHAR_SPACE) begin
              phase_next = PH_TRAIL;
            end
          end else begin
            failed_next = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_LEAD;
      octet      <= 9'd0;
      fcount     <= 3'd0;
      accum      <= 32'd0;
      name_pos   <= 4'd0;
      name_match <= 1'b1;
      failed     <= 1'b0;
    end else if (req.fire) begin
      phase      <= phase_next;
      octet      <= octet_next;
      fcount     <= fcount_next;
      accum      <= accum_next;
      name_pos   <= name_pos_next;
      name_match <= name_match_next;
      failed     <= failed_next;
    end
  end

endmodule

// ===== hw/rtl/ipv4p_out_reg.sv =====
// ============================================================================
// IPv4 parser result register
// Holds one result until the downstream side takes it.
// ============================================================================
module ipv4p_out_reg import ipv4p_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  res_t        res,
  output logic        out_ready,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        valid_res,
  output logic [31:0] address
);

  res_t held;

  assign out_ready = !out_valid || !out_stall;
  assign valid_res = held.valid_res;
  assign address   = held.address;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Capture a new request result
  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

endmodule

// ===== dv/tb_ipv4_dotted_text_parser_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// IPv4 dotted text parser testbench
// Streams zero-terminated strings into the parser one character at a time and
// checks every address result against an in-bench parse or a typed fixed row.
// Fixed strings come first, then random addresses, host names and junk text,
// with random idle and stall bursts, one long output hold and one drain pause.
// ============================================================================
module tb_ipv4_dotted_text_parser_top;
  import ipv4p_pkg::*;

  localparam int unsigned ITEM_TARGET = 1150;
  localparam int unsigned HOLD_AT     = 350;
  localparam int unsigned DRAIN_AT    = 650;
  localparam int unsigned CALM_AT     = 1000;
  localparam int unsigned HOLD_CYCLES = 60;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned DIR_ROWS    = 10;

  localparam logic [71:0] HOST_TEXT = "localhost";

  typedef enum logic [1:0] {
    SCAN_LEAD   = 2'd0,
    SCAN_FIELDS = 2'd1,
    SCAN_TRAIL  = 2'd2
  } scan_t;

  // Per-string note: typed results replace the parse for that string
  typedef struct packed {
    logic typed;
    res_t res;
  } end_note_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  char_code;
  logic        out_valid;
  logic        out_stall;
  logic        valid_res;
  logic [31:0] address;

  // Parse state mirrored in the bench
  scan_t       scan_phase;
  logic [8:0]  octet;
  logic [2:0]  field_cnt;
  logic [31:0] accum;
  logic [3:0]  name_pos;
  logic        name_ok;
  logic        failed;

  res_t        pending_results_q[$];
  end_note_t   end_notes_q[$];
  logic [7:0]  txt[$];

  int unsigned cycle_count = 0;
  int unsigned errors = 0;
  int unsigned results_seen = 0;
  int unsigned good_seen = 0;
  int unsigned loopback_seen = 0;
  bit          long_hold = 1'b0;
  bit          calm = 1'b0;
  bit          tx_gappy = 1'b1;

  // Fixed strings; rows with typed results are read straight off the rules
  string dir_text [DIR_ROWS] = '{
    "", "...", "localhost", " ..9.255 ", "999...", "....", "1 x", "\377",
    "1.2..3", "local.1.2"
  };
  bit    dir_typed [DIR_ROWS] = '{1, 1, 1, 1, 1, 1, 1, 1, 0, 0};
  res_t  dir_res [DIR_ROWS] = '{
    '{1'b0, 32'd0}, '{1'b1, 32'd0}, '{1'b1, LOOPBACK_ADDR}, '{1'b1, 32'h000009ff},
    '{1'b0, 32'd0}, '{1'b0, 32'd0}, '{1'b0, 32'd0}, '{1'b0, 32'd0},
    '{1'b0, 32'd0}, '{1'b0, 32'd0}
  };

  ipv4_dotted_text_parser_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .char_code (char_code),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .valid_res (valid_res),
    .address   (address)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Return the parse to its start state
  task automatic clear_parser();
    scan_phase = SCAN_LEAD;
    octet      = '0;
    field_cnt  = '0;
    accum      = '0;
    name_pos   = '0;
    name_ok    = 1'b1;
    failed     = 1'b0;
  endtask

  // Shift the current octet into the address
  task automatic commit_field();
    if (field_cnt < FIELD_SAT) field_cnt = field_cnt + 3'd1;
    if (octet > OCTET_MAX) failed = 1'b1;
    accum = {accum[23:0], octet[7:0]};
    octet = '0;
    if (field_cnt > FIELD_FULL) failed = 1'b1;
  endtask

  // Advance the parse by one character; the end character yields a result
  task automatic advance_parser(input logic [7:0] c, output bit done, output res_t r);
    logic [11:0] acc;
    done = 1'b0;
    r    = '0;
    if (c == CHAR_END) begin
      done = 1'b1;
      if (name_ok && name_pos == NAME_LEN) begin
        r.valid_res = 1'b1;
        r.address   = LOOPBACK_ADDR;
      end else begin
        if (!failed && scan_phase != SCAN_TRAIL) commit_field();
        r.valid_res = !failed && field_cnt == FIELD_FULL;
        r.address   = r.valid_res ? accum : 32'd0;
      end
      clear_parser();
    end else begin
      // track the host name regardless of the address parse
      if (name_ok && name_pos < NAME_LEN &&
          c == HOST_TEXT[8 * (8 - int'(name_pos)) +: 8]) begin
        name_pos = name_pos + 4'd1;
      end else begin
        name_ok = 1'b0;
      end
      if (!failed) begin
        if (scan_phase == SCAN_TRAIL) begin
          if (c != CHAR_SPACE) failed = 1'b1;
        end else if (!(scan_phase == SCAN_LEAD && c == CHAR_SPACE)) begin
          scan_phase = SCAN_FIELDS;
          if (c >= CHAR_DIG0 && c <= CHAR_DIG9) begin
            acc   = {3'd0, octet} * 12'd10 + {4'd0, c - CHAR_DIG0};
            octet = (acc > OCTET_SAT) ? OCTET_SAT[8:0] : acc[8:0];
          end else if (c == CHAR_DOT) begin
            commit_field();
          end else if (c == CHAR_SPACE) begin
            commit_field();
            scan_phase = SCAN_TRAIL;
          end else begin
            failed = 1'b1;
          end
        end
      end
    end
  endtask

  // Check results and predict on every accepted request
  always @(posedge clk) begin : monitor
    bit        done;
    res_t      got;
    res_t      want;
    end_note_t note;
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_results_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("tb: unexpected result valid_res %0b address %h", valid_res, address);
        end else begin
          want = pending_results_q.pop_front();
          if (valid_res !== want.valid_res || address !== want.address) begin
            errors++;
            if (errors <= 10)
              $display("tb: result %0d mismatch: valid_res exp %0b got %0b, address exp %h got %h",
                       results_seen, want.valid_res, valid_res, want.address, address);
          end
          if (want.valid_res) good_seen++;
          if (want.valid_res && want.address == LOOPBACK_ADDR) loopback_seen++;
        end
      end
      if (in_valid && !in_stall) begin
        advance_parser(char_code, done, got);
        if (done) begin
          note = end_notes_q.pop_front();
          pending_results_q.insert(pending_results_q.size(), note.typed ? note.res : got);
        end
      end
    end
  end

  // Offer one request and hold it until it is taken
  task automatic put_char(input logic [7:0] c);
    if (!calm && tx_gappy && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Add one character at the end of the string being built
  task automatic append_txt(input logic [7:0] c);
    txt.insert(txt.size(), c);
  endtask

  task automatic push_decimal(input int unsigned v);
    logic [7:0] digs[$];
    do begin
      digs.push_front(8'(CHAR_DIG0 + v % 10));
      v = v / 10;
    end while (v != 0);
    foreach (digs[i]) append_txt(digs[i]);
  endtask

  // Build one random string: mostly addresses, some host names, some junk
  task automatic compose_string();
    int unsigned kind;
    int unsigned n;
    int unsigned pos;
    logic [7:0]  c;
    txt.delete();
    kind = $urandom_range(0, 99);
    if (kind < 58) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 5) : 4;
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 2)) append_txt(CHAR_SPACE);
      for (int f = 0; f < n; f++) begin
        if (f != 0) append_txt(CHAR_DOT);
        if ($urandom_range(0, 11) != 0) begin
          if ($urandom_range(0, 9) == 0) append_txt(CHAR_DIG0);
          push_decimal(($urandom_range(0, 6) == 0) ? $urandom_range(256, 999)
                                                   : $urandom_range(0, 255));
        end
      end
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) append_txt(CHAR_SPACE);
      // break the address now and then
      if ($urandom_range(0, 14) == 0) begin
        pos = $urandom_range(0, txt.size() - 1);
        txt.insert(pos, 8'($urandom_range(1, 255)));
      end
    end else if (kind < 68) begin
      for (int i = 0; i < 9; i++) append_txt(HOST_TEXT[8 * (8 - i) +: 8]);
      case ($urandom_range(0, 3))
        0: txt = txt[0:$urandom_range(0, 7)];
        1: append_txt(8'($urandom_range(1, 255)));
        2: txt[$urandom_range(0, 8)] = 8'($urandom_range(1, 255));
        default: ;
      endcase
    end else begin
      repeat ($urandom_range(1, 8)) begin
        case ($urandom_range(0, 3))
          0, 1: c = 8'($urandom_range(1, 255));
          2:    c = 8'(CHAR_DIG0 + $urandom_range(0, 9));
          default: c = $urandom_range(0, 1) ? CHAR_DOT : CHAR_SPACE;
        endcase
        append_txt(c);
      end
    end
  endtask

  // Receiver: random stall bursts, quiet stretches, and one long hold
  initial begin : receiver
    bit rx_quiet;
    rx_quiet  = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 63) == 0) rx_quiet = !rx_quiet;
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        long_hold = 1'b0;
      end else if (!calm && !rx_quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int unsigned sent;
    int unsigned strings;
    bit          held;
    bit          drained;
    string       row;
    sent      = 0;
    strings   = 0;
    held      = 1'b0;
    drained   = 1'b0;
    rst       = 1'b1;
    in_valid  = 1'b0;
    char_code = 8'd0;
    clear_parser();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // fixed strings
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = dir_text[i];
      end_notes_q.insert(end_notes_q.size(), end_note_t'{dir_typed[i], dir_res[i]});
      for (int k = 0; k < row.len(); k++) put_char(row[k]);
      put_char(CHAR_END);
      sent += row.len() + 1;
      strings++;
    end

    // random strings
    while (sent < ITEM_TARGET) begin
      if (!held && sent >= HOLD_AT) begin
        long_hold = 1'b1;
        held      = 1'b1;
      end
      if (!drained && sent >= DRAIN_AT) begin
        in_valid <= 1'b0;
        wait (pending_results_q.size() == 0);
        @(negedge clk);
        drained = 1'b1;
      end
      if (sent >= CALM_AT) calm = 1'b1;
      tx_gappy = $urandom_range(0, 2) != 0;
      compose_string();
      end_notes_q.insert(end_notes_q.size(), end_note_t'{1'b0, res_t'('0)});
      foreach (txt[k]) put_char(txt[k]);
      put_char(CHAR_END);
      sent += txt.size() + 1;
      strings++;
    end
    in_valid <= 1'b0;

    wait (pending_results_q.size() == 0);
    repeat (8) @(posedge clk);
    $display("tb: %0d characters in %0d strings, %0d results, %0d well formed, %0d loopback",
             sent, strings, results_seen, good_seen, loopback_seen);
    $display("tb: long output hold and drain pause done, %0d errors", errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
